### rtl/mau_pkg.sv
package mau_pkg;

    localparam int WIDTH = 64;
    localparam int CNT_W = $clog2(WIDTH + 1);

    localparam logic [WIDTH-1:0] MODULUS_RESET = WIDTH'(64'd2305843009213693951);

    typedef enum logic [2:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_POW = 3'd3,
        CMD_DIV = 3'd4
    } cmd_t;

endpackage

### rtl/modular_arithmetic_unit.sv
// channel | signals                                     | accepted when
// in      | in_valid in_ready command operand_a operand_b | in_valid && in_ready
// out     | out_valid out_ready result                    | out_valid && out_ready
// cfg     | cfg_we cfg_wdata                              | cfg_we
//
// one item at a time; a multiply pass handles one multiplier bit a cycle
// reduction of a, then of b (restoring, one quotient bit a cycle)
// add/sub: result set in the dispatch state after both reductions; mul: one multiply pass more
// power: per exponent bit a step state plus one or two passes, then the finish state
// divide: power on p-2 plus one pass
// reset: modulus takes 2^61-1, no item held; a waiting result holds off the next item
module modular_arithmetic_unit
    import mau_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [63:0]      cfg_wdata,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [2:0]       command,
    input  logic [63:0]      operand_a,
    input  logic [63:0]      operand_b,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [63:0]      result
);

    typedef enum logic [3:0] {
        S_IDLE, S_REDA, S_REDB, S_DISP, S_MUL, S_PSTEP, S_DFIN, S_DONE
    } state_t;

    // pow phases: what the current multiply produces
    typedef enum logic [1:0] {
        PH_ACC, PH_SQR, PH_FIN
    } phase_t;

    state_t           state_reg;
    phase_t           phase_reg;
    logic [WIDTH-1:0] p_reg;
    logic [2:0]       cmd_reg;
    logic [WIDTH-1:0] a_reg, b_reg, e_reg;
    logic [WIDTH-1:0] base_reg, acc_reg;
    logic [WIDTH-1:0] rem_reg, dvd_reg;
    logic [WIDTH-1:0] mx_reg, my_reg, macc_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [63:0]      result_reg;

    // modular add of two values below p, width +1 to catch the carry
    function automatic logic [WIDTH-1:0] madd(input logic [WIDTH-1:0] x,
                                              input logic [WIDTH-1:0] y,
                                              input logic [WIDTH-1:0] m);
        logic [WIDTH:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m})
            s = s - {1'b0, m};
        return s[WIDTH-1:0];
    endfunction

    logic [WIDTH:0]   rem_sh;
    logic [WIDTH-1:0] rem_nx;
    logic [WIDTH-1:0] dbl, dbl_add;

    always_comb
    begin
        rem_sh = {rem_reg, dvd_reg[WIDTH-1]};
        rem_nx = (rem_sh >= {1'b0, p_reg}) ? WIDTH'(rem_sh - {1'b0, p_reg})
                                           : rem_sh[WIDTH-1:0];
        dbl     = madd(macc_reg, macc_reg, p_reg);
        dbl_add = my_reg[WIDTH-1] ? madd(dbl, mx_reg, p_reg) : dbl;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_DONE);
    assign result    = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            p_reg      <= MODULUS_RESET;
            phase_reg  <= PH_ACC;
            cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
                p_reg <= cfg_wdata[WIDTH-1:0];
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg <= command;
                        a_reg   <= operand_a[WIDTH-1:0];
                        b_reg   <= operand_b[WIDTH-1:0];
                        e_reg   <= operand_b[WIDTH-1:0];
                        rem_reg <= '0;
                        dvd_reg <= operand_a[WIDTH-1:0];
                        cnt_reg <= CNT_W'(WIDTH);
                        state_reg <= (p_reg < WIDTH'(2)) ? S_DONE : S_REDA;
                        result_reg <= '0;
                    end
                end
                // restoring reduction one dividend bit a cycle
                S_REDA, S_REDB:
                begin
                    rem_reg <= rem_nx;
                    dvd_reg <= {dvd_reg[WIDTH-2:0], 1'b0};
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                    begin
                        if (state_reg == S_REDA)
                        begin
                            a_reg   <= rem_nx;
                            rem_reg <= '0;
                            dvd_reg <= b_reg;
                            cnt_reg <= CNT_W'(WIDTH);
                            state_reg <= S_REDB;
                        end
                        else
                        begin
                            b_reg <= rem_nx;
                            state_reg <= S_DISP;
                        end
                    end
                end
                S_DISP:
                begin
                    state_reg <= S_DONE;
                    case (cmd_reg)
                        CMD_ADD: result_reg <= 64'(madd(a_reg, b_reg, p_reg));
                        CMD_SUB: result_reg <= 64'((a_reg < b_reg)
                                     ? WIDTH'(p_reg - (b_reg - a_reg))
                                     : WIDTH'(a_reg - b_reg));
                        CMD_MUL:
                        begin
                            mx_reg <= a_reg; my_reg <= b_reg; macc_reg <= '0;
                            cnt_reg <= CNT_W'(WIDTH);
                            phase_reg <= PH_FIN;
                            state_reg <= S_MUL;
                        end
                        CMD_POW:
                        begin
                            base_reg <= a_reg; acc_reg <= WIDTH'(1);
                            state_reg <= S_PSTEP;
                        end
                        CMD_DIV:
                        begin
                            if (b_reg != '0)
                            begin
                                base_reg <= b_reg; acc_reg <= WIDTH'(1);
                                e_reg <= p_reg - WIDTH'(2);
                                state_reg <= S_PSTEP;
                            end
                        end
                        default: result_reg <= '0;
                    endcase
                end
                // one square-and-multiply decision per exponent bit
                S_PSTEP:
                begin
                    if (e_reg == '0)
                        state_reg <= S_DFIN;
                    else
                    begin
                        if (e_reg[0])
                        begin
                            mx_reg <= acc_reg; my_reg <= base_reg;
                            phase_reg <= PH_ACC;
                        end
                        else
                        begin
                            mx_reg <= base_reg; my_reg <= base_reg;
                            phase_reg <= PH_SQR;
                        end
                        macc_reg <= '0;
                        cnt_reg <= CNT_W'(WIDTH);
                        state_reg <= S_MUL;
                    end
                end
                // shift-add multiply, one multiplier bit a cycle msb first
                S_MUL:
                begin
                    macc_reg <= dbl_add;
                    my_reg   <= {my_reg[WIDTH-2:0], 1'b0};
                    cnt_reg  <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                    begin
                        unique case (phase_reg)
                            PH_ACC:
                            begin
                                acc_reg <= dbl_add;
                                mx_reg <= base_reg; my_reg <= base_reg;
                                macc_reg <= '0;
                                cnt_reg <= CNT_W'(WIDTH);
                                phase_reg <= PH_SQR;
                            end
                            PH_SQR:
                            begin
                                base_reg <= dbl_add;
                                e_reg <= e_reg >> 1;
                                state_reg <= S_PSTEP;
                            end
                            default:
                            begin
                                result_reg <= 64'(dbl_add);
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_DFIN:
                begin
                    if (cmd_reg == CMD_POW)
                    begin
                        result_reg <= 64'(acc_reg);
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        mx_reg <= a_reg; my_reg <= acc_reg; macc_reg <= '0;
                        cnt_reg <= CNT_W'(WIDTH);
                        phase_reg <= PH_FIN;
                        state_reg <= S_MUL;
                    end
                end
                S_DONE:
                begin
                    if (out_ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // a finished result stays below the modulus
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && p_reg >= WIDTH'(2)) |-> (result_reg[WIDTH-1:0] < p_reg))
        else $error("result not reduced");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(result_reg)))
        else $error("waiting result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> (cnt_reg != '0))
        else $error("multiply counter ran out");

endmodule

### dv/tb.sv
module tb;
    import mau_pkg::*;

    localparam logic [63:0] P61 = 64'd2305843009213693951;
    localparam logic [63:0] P64 = 64'hFFFF_FFFF_FFFF_FFC5;
    localparam logic [63:0] P32 = 64'd4294967291;
    localparam logic [63:0] ONES = '1;
    localparam logic [2:0] CMD_UNUSED = 3'd5;
    localparam int LIMIT = 6000000;

    typedef struct {
        logic [63:0] modulus;
        logic [2:0]  cmd;
        logic [63:0] a;
        logic [63:0] b;
        bit          typed;
        logic [63:0] want;
    } row_t;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [63:0] cfg_wdata = '0;
    logic        in_valid = 0;
    logic        in_ready;
    logic [2:0]  command = CMD_ADD;
    logic [63:0] operand_a = '0;
    logic [63:0] operand_b = '0;
    logic        out_valid;
    logic        out_ready = 0;
    logic [63:0] result;

    logic [63:0] cur_modulus = P61;
    logic [63:0] expected_results[$];
    int          errors = 0;
    int          cycles = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          hold_left = 0;
    row_t        rows[$];

    modular_arithmetic_unit uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .command(command),
        .operand_a(operand_a), .operand_b(operand_b),
        .out_valid(out_valid), .out_ready(out_ready), .result(result)
    );

    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    function automatic logic [63:0] mul_mod(logic [63:0] x, logic [63:0] y, logic [63:0] p);
        logic [127:0] prod;
        prod = 128'(x) * 128'(y);
        return 64'(prod % 128'(p));
    endfunction

    function automatic logic [63:0] pow_mod(logic [63:0] base, logic [63:0] e, logic [63:0] p);
        logic [63:0] acc;
        acc = 1;
        while (e != 0)
        begin
            if (e[0])
                acc = mul_mod(acc, base, p);
            base = mul_mod(base, base, p);
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic logic [63:0] modular_result(logic [2:0] cmd, logic [63:0] a,
                                                   logic [63:0] b, logic [63:0] p);
        logic [63:0] ar;
        logic [63:0] br;
        logic [64:0] sum;
        if (p < 2)
            return '0;
        ar = a % p;
        br = b % p;
        case (cmd)
            CMD_ADD:
            begin
                sum = {1'b0, ar} + {1'b0, br};
                return 64'(sum % {1'b0, p});
            end
            CMD_SUB: return (ar >= br) ? ar - br : p - (br - ar);
            CMD_MUL: return mul_mod(ar, br, p);
            CMD_POW: return pow_mod(ar, b, p);
            CMD_DIV: return (br == 0) ? '0 : mul_mod(ar, pow_mod(br, p - 2, p), p);
            default: return '0;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // result side: check accepted items, stall at random or hold off for a stretch
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", result, '0);
            else if (result !== expected_results[0])
                report_mismatch("result", result, expected_results.pop_front());
            else
                void'(expected_results.pop_front());
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 0;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic set_modulus(logic [63:0] value);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we <= 1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 0;
        cur_modulus = value;
    endtask

    // valid stays high across back-to-back items, lowered only for a gap
    task automatic send_item(logic [2:0] cmd, logic [63:0] a, logic [63:0] b,
                             bit typed, logic [63:0] want);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        in_valid <= 1;
        command <= cmd;
        operand_a <= a;
        operand_b <= b;
        expected_results.push_back(typed ? want : modular_result(cmd, a, b, cur_modulus));
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic random_phase(logic [63:0] modulus, int count);
        logic [2:0]  cmd;
        logic [63:0] a;
        logic [63:0] b;
        in_valid <= 0;
        set_modulus(modulus);
        repeat (count)
        begin
            cmd = ($urandom_range(19) == 0) ? CMD_UNUSED + 3'($urandom_range(2))
                                            : 3'($urandom_range(CMD_DIV));
            a = rand64();
            b = rand64();
            if (modulus != 0 && $urandom_range(3) != 0)
            begin
                a = a % modulus;
                if (cmd != CMD_POW)
                    b = b % modulus;
            end
            send_item(cmd, a, b, 0, '0);
        end
    endtask

    initial
    begin
        // modulus, command, a, b, typed, expected
        rows = '{
            '{P61, CMD_ADD, 0, 0, 1, 0},
            '{P61, CMD_ADD, P61 - 1, 1, 1, 0},
            '{P61, CMD_SUB, 0, 1, 1, P61 - 1},
            '{P61, CMD_MUL, P61 - 1, P61 - 1, 1, 1},
            '{P61, CMD_POW, 5, 0, 1, 1},
            '{P61, CMD_POW, 2, 61, 1, 1},
            '{P61, CMD_DIV, 7, 0, 1, 0},
            '{P61, CMD_DIV, 6, 3, 1, 2},
            '{P61, CMD_UNUSED, 3, 4, 1, 0},
            '{P61, CMD_UNUSED + 3'd1, 3, 4, 1, 0},
            '{P61, CMD_UNUSED + 3'd2, ONES, ONES, 1, 0},
            '{P61, CMD_ADD, ONES, ONES, 0, 0},
            '{P61, CMD_POW, 3, ONES, 0, 0},
            '{P64, CMD_MUL, ONES, ONES, 0, 0},
            '{P64, CMD_SUB, 0, P64 - 1, 1, 1},
            '{P64, CMD_POW, P64 - 1, ONES, 0, 0},
            '{P64, CMD_DIV, ONES, 12345, 0, 0},
            '{P64, CMD_DIV, 5, P64, 1, 0},
            '{1, CMD_MUL, 7, 9, 1, 0},
            '{0, CMD_ADD, 5, 5, 1, 0},
            '{2, CMD_ADD, 1, 1, 1, 0},
            '{2, CMD_POW, 1, ONES, 1, 1},
            '{1000, CMD_DIV, 3, 7, 0, 0}
        };
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].modulus != cur_modulus)
            begin
                in_valid <= 0;
                set_modulus(rows[i].modulus);
            end
            send_item(rows[i].cmd, rows[i].a, rows[i].b, rows[i].typed, rows[i].want);
        end

        random_phase(P61, 18);
        idle_pct = 66;
        random_phase(P32, 18);
        idle_pct = 0;
        stall_pct = 66;
        random_phase(13, 18);
        idle_pct = 32;
        stall_pct = 32;
        random_phase(P64, 18);

        // long receiver hold-off while items keep coming
        idle_pct = 0;
        stall_pct = 0;
        in_valid <= 0;
        set_modulus(rand64() | 64'd3);
        hold_left = 3000;
        repeat (8)
            send_item(3'($urandom_range(CMD_SUB)), rand64(), rand64(), 0, '0);
        in_valid <= 0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
